### sv/yrgb_pkg.sv
// Shared types and fixed coefficients for the YUV to RGB pixel converter.
// No dependencies; imported by yrgb_matrix and yuv_to_rgb_pixel_converter.
`default_nettype none

package yrgb_pkg;

   // One input transaction: a pixel's luma and its shared chroma pair.
   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } req_type;

   // One result transaction: saturated 8-bit RGB.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // Width of the signed datapath; every intermediate fits here.
   localparam int unsigned SumWidth = 16;
   localparam int unsigned FracBits = 5;

   localparam logic signed [SumWidth-1:0] LumaOffset   = 16'sd16;
   localparam logic signed [SumWidth-1:0] ChromaOffset = 16'sd127;
   localparam logic signed [SumWidth-1:0] CoefY        = 16'sd37;
   localparam logic signed [SumWidth-1:0] CoefRv       = 16'sd51;
   localparam logic signed [SumWidth-1:0] CoefBu       = 16'sd65;
   localparam logic signed [SumWidth-1:0] CoefGu       = 16'sd13;
   localparam logic signed [SumWidth-1:0] CoefGv       = 16'sd26;

endpackage

`default_nettype wire

### sv/yrgb_matrix.sv
// Combinational color matrix: offset removal, constant multiplies,
// arithmetic shift and saturation. Depends on yrgb_pkg.
`default_nettype none

module yrgb_matrix
   import yrgb_pkg::*;
(
   input  req_type pixel_yuv,
   output rsp_type pixel_rgb
);

   localparam int unsigned ShiftWidth = SumWidth - FracBits;

   // Floor-shift then clamp to 0..255.
   function automatic logic [7:0] scale_clamp(input logic signed [SumWidth-1:0] sum);
      logic signed [SumWidth-1:0]   shifted;
      logic signed [ShiftWidth-1:0] narrow;
      logic [7:0]                   result;
      shifted = sum >>> FracBits;
      narrow  = shifted[ShiftWidth-1:0];
      if (narrow < 0) begin
         result = 8'd0;
      end else if (narrow > $signed(ShiftWidth'(255))) begin
         result = 8'd255;
      end else begin
         result = narrow[7:0];
      end
      return result;
   endfunction

   logic signed [SumWidth-1:0] y_ofs;
   logic signed [SumWidth-1:0] u_ofs;
   logic signed [SumWidth-1:0] v_ofs;
   logic signed [SumWidth-1:0] y_term;
   logic signed [SumWidth-1:0] red_sum;
   logic signed [SumWidth-1:0] green_sum;
   logic signed [SumWidth-1:0] blue_sum;

   always_comb begin
      y_ofs = $signed({{(SumWidth-8){1'b0}}, pixel_yuv.luma}) - LumaOffset;
      u_ofs = $signed({{(SumWidth-8){1'b0}}, pixel_yuv.chroma_blue}) - ChromaOffset;
      v_ofs = $signed({{(SumWidth-8){1'b0}}, pixel_yuv.chroma_red}) - ChromaOffset;

      y_term    = CoefY * y_ofs;
      red_sum   = y_term + CoefRv * v_ofs;
      blue_sum  = y_term + CoefBu * u_ofs;
      green_sum = y_term - (CoefGu * u_ofs + CoefGv * v_ofs);

      pixel_rgb.red   = scale_clamp(red_sum);
      pixel_rgb.green = scale_clamp(green_sum);
      pixel_rgb.blue  = scale_clamp(blue_sum);
   end

endmodule

`default_nettype wire

### sv/yuv_to_rgb_pixel_converter.sv
// Top level of the YUV to RGB pixel converter: input register, color
// matrix and result register. Depends on yrgb_pkg and yrgb_matrix.
`default_nettype none

// One pixel transaction is taken on every clock where start is high; busy
// is always low, so a source may stream one pixel per cycle without gaps.
// Each transaction yields exactly one RGB result, shown on rsp_data for a
// single cycle with rsp_valid high. The pixel waits in the input register
// while the color matrix works on it, then the result waits in the result
// register until the edge that ends its valid cycle, where it is taken.
// Results leave in arrival order and cannot be held off: the receiver must
// take each one in the cycle it appears. Throughput is one pixel per clock,
// set by the single register-to-register pass through the color matrix.
// The 4:2:0 chroma sharing, frame addressing and RGB byte packing are up
// to the source and sink. Reset clears only the valid flags.
module yuv_to_rgb_pixel_converter
   import yrgb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // Input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff,  in_data_in;

   // Result stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff,  out_data_in;

   logic    accept;
   rsp_type matrix_rgb;

   // Fully pipelined: never stalls the source.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign in_valid_in  = accept;
   assign in_data_in   = req_data;
   assign out_valid_in = in_valid_ff;
   assign out_data_in  = matrix_rgb;

   yrgb_matrix u_matrix (
      .pixel_yuv (in_data_ff),
      .pixel_rgb (matrix_rgb)
   );

   // Valid flags are control state and reset; payload just follows.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= in_data_in;
      end
      if (in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Every result strobe traces back to an accepted transaction, through the input and result registers.
   a_rsp_follows_req: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2)
   ) else $error("result strobe without matching transaction");

   // Each accepted transaction produces a result strobe once it has passed the input and result registers.
   a_req_makes_rsp: assert property (
      @(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid
   ) else $error("accepted transaction produced no result");

   // Neutral chroma gives a gray pixel: all three channels match.
   a_neutral_gray: assert property (
      @(posedge clock) disable iff (reset)
      (accept && req_data.chroma_blue == 8'd127 && req_data.chroma_red == 8'd127)
         |-> ##2 (rsp_data.red == rsp_data.green && rsp_data.green == rsp_data.blue)
   ) else $error("neutral chroma did not give a gray result");

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for yuv_to_rgb_pixel_converter: a directed pixel table, then
// random pixel bursts, every result checked against an in-bench color matrix model.
// Depends on yrgb_pkg (req_type, rsp_type) and the converter RTL.
`timescale 1ns / 100ps

module tb
   import yrgb_pkg::*;
();

   // Color matrix constants, kept local so the model does not lean on the RTL package.
   localparam int LumaBias    = 16;
   localparam int ChromaBias  = 127;
   localparam int CoefLuma    = 37;
   localparam int CoefRedV    = 51;
   localparam int CoefBlueU   = 65;
   localparam int CoefGreenU  = 13;
   localparam int CoefGreenV  = 26;
   localparam int FracShift   = 5;

   localparam int  RandomPixels = 700;
   localparam int  DrainCycles  = 8;      // pipeline is two deep; a few spare cycles
   localparam int  CycleLimit   = 100000; // watchdog bound; the worst run stays well under it
   localparam bit  HasRgb       = 1'b1;
   localparam bit  NoRgb        = 1'b0;

   // Row of the directed table: pixel in, and an RGB value typed in by hand
   // where it is obvious (offsets removed to zero, hard saturation, etc.).
   typedef struct packed {
      req_type px;
      logic    has_rgb;
      rsp_type rgb;
   } pixel_row_type;

   localparam int NumRows = 24;

   // {luma, chroma_blue, chroma_red, flag, red, green, blue}
   pixel_row_type pixel_table [0:NumRows-1] = '{
      // all-zero input: red/blue far negative, green positive
      {8'd0,   8'd0,   8'd0,   HasRgb, 8'd0,   8'd136, 8'd0  },
      // all-ones input: red/blue overflow, green in range
      {8'd255, 8'd255, 8'd255, HasRgb, 8'd255, 8'd120, 8'd255},
      // black point, neutral chroma
      {8'd16,  8'd127, 8'd127, HasRgb, 8'd0,   8'd0,   8'd0  },
      {8'd255, 8'd127, 8'd127, HasRgb, 8'd255, 8'd255, 8'd255},
      {8'd0,   8'd127, 8'd127, HasRgb, 8'd0,   8'd0,   8'd0  },
      {8'd235, 8'd127, 8'd127, HasRgb, 8'd253, 8'd253, 8'd253},
      // luma one step each side of its offset
      {8'd15,  8'd127, 8'd127, HasRgb, 8'd0,   8'd0,   8'd0  },
      {8'd17,  8'd127, 8'd127, HasRgb, 8'd1,   8'd1,   8'd1  },
      // each chroma alone at its extremes
      {8'd16,  8'd127, 8'd0,   HasRgb, 8'd0,   8'd103, 8'd0  },
      {8'd16,  8'd127, 8'd255, HasRgb, 8'd204, 8'd0,   8'd0  },
      {8'd16,  8'd0,   8'd127, HasRgb, 8'd0,   8'd51,  8'd0  },
      {8'd16,  8'd255, 8'd127, HasRgb, 8'd0,   8'd0,   8'd255},
      // model-checked rows: bit patterns, mid tones, chroma one off neutral
      {8'hAA,  8'h55,  8'hAA,  NoRgb,  24'h0},
      {8'h55,  8'hAA,  8'h55,  NoRgb,  24'h0},
      {8'd128, 8'd128, 8'd128, NoRgb,  24'h0},
      {8'd100, 8'd200, 8'd50,  NoRgb,  24'h0},
      {8'd200, 8'd50,  8'd200, NoRgb,  24'h0},
      {8'd81,  8'd90,  8'd240, NoRgb,  24'h0},
      {8'd145, 8'd54,  8'd34,  NoRgb,  24'h0},
      {8'd41,  8'd240, 8'd110, NoRgb,  24'h0},
      {8'd255, 8'd0,   8'd255, NoRgb,  24'h0},
      {8'd0,   8'd255, 8'd0,   NoRgb,  24'h0},
      {8'd128, 8'd126, 8'd128, NoRgb,  24'h0},
      {8'd16,  8'd128, 8'd126, NoRgb,  24'h0}
   };

   logic    clock;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Hand-typed RGB riding along with the pixel on the request side.
   rsp_type typed_rgb   = '0;
   logic    typed_valid = 1'b0;

   rsp_type expected_rgb [$];
   rsp_type want_rgb;
   int      errors      = 0;
   int      cycle_count = 0;
   int      burst_left  = 0;

   yuv_to_rgb_pixel_converter uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] clip_to_byte(input int v);
      if (v < 0)
         return 8'd0;
      if (v > 255)
         return 8'd255;
      return v[7:0];
   endfunction

   // Color matrix: remove offsets, scale, floor-shift (>>> on int), saturate.
   function automatic rsp_type convert_pixel(input req_type px);
      int      y_term;
      int      u_term;
      int      v_term;
      int      luma_scaled;
      rsp_type rgb;
      y_term      = int'(px.luma) - LumaBias;
      u_term      = int'(px.chroma_blue) - ChromaBias;
      v_term      = int'(px.chroma_red) - ChromaBias;
      luma_scaled = CoefLuma * y_term;
      rgb.red   = clip_to_byte((luma_scaled + CoefRedV * v_term) >>> FracShift);
      rgb.green = clip_to_byte((luma_scaled - (CoefGreenU * u_term + CoefGreenV * v_term))
                               >>> FracShift);
      rgb.blue  = clip_to_byte((luma_scaled + CoefBlueU * u_term) >>> FracShift);
      return rgb;
   endfunction

   // Random sample, biased a quarter of the time toward the offsets and the rails.
   function automatic logic [7:0] pick_sample();
      if ($urandom_range(0, 3) != 0)
         return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd15;
         3:       return 8'd16;
         4:       return 8'd17;
         5:       return 8'd126;
         6:       return 8'd127;
         7:       return 8'd128;
         8:       return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   // Present one pixel and hold it until the block takes the transaction.
   // The sender runs in bursts; when a burst is used up, start drops for a
   // random gap so idle cycles land at every stage of the two-deep pipe.
   task automatic send_pixel(input req_type px, input logic has_rgb, input rsp_type rgb);
      int gap;
      req_data    <= px;
      typed_rgb   <= rgb;
      typed_valid <= has_rgb;
      start       <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 40);
         start      <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every outstanding transaction has produced its result.
   // The first edge lets start drop before the queue is polled.
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_rgb.size() != 0)
         @(posedge clock);
   endtask

   // Scoreboard: results are checked before this edge's acceptance is queued,
   // so a result can never be matched against the pixel taken on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_rgb.size() == 0) begin
               $error("rsp: result %h with no transaction pending", rsp_data);
               errors++;
            end else begin
               want_rgb = expected_rgb.pop_front();
               if (rsp_data.red !== want_rgb.red) begin
                  $error("red: expected %0d, got %0d", want_rgb.red, rsp_data.red);
                  errors++;
               end
               if (rsp_data.green !== want_rgb.green) begin
                  $error("green: expected %0d, got %0d", want_rgb.green, rsp_data.green);
                  errors++;
               end
               if (rsp_data.blue !== want_rgb.blue) begin
                  $error("blue: expected %0d, got %0d", want_rgb.blue, rsp_data.blue);
                  errors++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            expected_rgb.push_back(typed_valid ? typed_rgb : convert_pixel(req_data));
      end
   end

   // Watchdog: a hung handshake or a lost result ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_type px;
      // Synchronous reset, asserted from time zero and then released.
      repeat (5) @(posedge clock);
      reset      <= 1'b0;
      burst_left = $urandom_range(1, 40);
      @(posedge clock);

      // Directed table: extremes, saturation on both rails, neutral chroma.
      for (int row = 0; row < NumRows; row++)
         send_pixel(pixel_table[row].px, pixel_table[row].has_rgb, pixel_table[row].rgb);

      // Full stop: source quiet until the pipe is empty.
      wait_for_drain();

      // Random pixel stream in bursts.
      for (int n = 0; n < RandomPixels; n++) begin
         px.luma        = pick_sample();
         px.chroma_blue = pick_sample();
         px.chroma_red  = pick_sample();
         send_pixel(px, NoRgb, '0);
      end

      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
